[rtl/core/aou_pkg.sv]
// ----------------------------------------------------------------------------
// aou_pkg
// Shared constants, types and arithmetic step functions of the Adam update.
// ----------------------------------------------------------------------------
package aou_pkg;

    localparam int WEIGHT_ENTRIES = 4096;
    localparam int BIAS_ENTRIES   = 256;
    localparam int WADDR_W = (WEIGHT_ENTRIES > 1) ? $clog2(WEIGHT_ENTRIES) : 1;
    localparam int BADDR_W = (BIAS_ENTRIES > 1) ? $clog2(BIAS_ENTRIES) : 1;
    localparam int CLR_ENTRIES =
        (WEIGHT_ENTRIES > BIAS_ENTRIES) ? WEIGHT_ENTRIES : BIAS_ENTRIES;
    localparam int CLR_W = (CLR_ENTRIES > 1) ? $clog2(CLR_ENTRIES) : 1;

    localparam int IDX_W    = 12;
    localparam int VH_STEPS = 48;
    localparam int MH_STEPS = 32;
    localparam int SQ_STEPS = 32;
    localparam int DQ_STEPS = 32;

    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
    localparam logic [24:0] ONE_Q24 = 25'h100_0000;

    localparam logic [31:0] LR_RST   = 32'd4294967;
    localparam logic [23:0] B1_RST   = 24'd15099494;
    localparam logic [23:0] B2_RST   = 24'd16760438;
    localparam logic [23:0] EPS_RST  = 24'd10995;

    typedef enum logic [1:0] {
        REG_LEARNING_RATE = 2'd0,
        REG_BETA_ONE      = 2'd1,
        REG_BETA_TWO      = 2'd2,
        REG_EPSILON       = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] m;
        logic [47:0] v;
    } mom_t;

    typedef struct packed {
        logic             en;
        logic             bank;
        logic [IDX_W-1:0] idx;
        mom_t             data;
    } mwr_t;

    typedef struct packed {
        logic             valid;
        logic             upd;
        logic             bank;
        logic [IDX_W-1:0] idx;
        logic [31:0]      w;
        logic             neg;
    } hdr_t;

    typedef struct packed {
        hdr_t        hdr;
        logic [31:0] mmag;
        logic [47:0] v;
        logic [32:0] d1;
        logic [32:0] d2;
    } corr_in_t;

    typedef struct packed {
        logic             valid;
        logic             bank;
        logic [IDX_W-1:0] idx;
        logic [31:0]      nw;
    } res_t;

    // one restoring division step, remainder below a divisor of at most 2^32
    function automatic logic [32:0] div_step32(input logic [31:0] rem, input logic nb,
                                               input logic [32:0] den);
        logic [32:0] t;
        t = {rem, nb};
        if (t >= den) begin
            div_step32 = {1'b1, 32'(t - den)};
        end else begin
            div_step32 = {1'b0, t[31:0]};
        end
    endfunction

    function automatic logic [49:0] div_step49(input logic [48:0] rem, input logic nb,
                                               input logic [48:0] den);
        logic [49:0] t;
        t = {rem, nb};
        if (t >= {1'b0, den}) begin
            div_step49 = {1'b1, 49'(t - {1'b0, den})};
        end else begin
            div_step49 = {1'b0, t[48:0]};
        end
    endfunction

    // returns {root, rem}
    function automatic logic [65:0] sqrt_step(input logic [33:0] rem, input logic [1:0] bits,
                                              input logic [31:0] root);
        logic [35:0] r;
        logic [35:0] t;
        r = {rem, bits};
        t = {2'b00, root, 2'b01};
        if (r >= t) begin
            sqrt_step = {root[30:0], 1'b1, 34'(r - t)};
        end else begin
            sqrt_step = {root[30:0], 1'b0, r[33:0]};
        end
    endfunction

endpackage

[rtl/core/aou_mstore.sv]
// ----------------------------------------------------------------------------
// aou_mstore
// Moment memories for both banks, registered read, clearing sweep after reset.
// ----------------------------------------------------------------------------
module aou_mstore import aou_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             rd_en,
    input  logic             rd_bank,
    input  logic [IDX_W-1:0] rd_idx,
    input  mwr_t             wr,
    output mom_t             rd_data,
    output logic             busy
);

    mom_t wmem [WEIGHT_ENTRIES];
    mom_t bmem [BIAS_ENTRIES];

    mom_t             wrd_reg;
    mom_t             brd_reg;
    logic             rbank_reg;
    logic [CLR_W-1:0] clr_cnt_reg;
    logic             busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b1;
            clr_cnt_reg <= '0;
        end else if (busy_reg) begin
            if (clr_cnt_reg == CLR_W'(CLR_ENTRIES - 1)) begin
                busy_reg <= 1'b0;
            end
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            if (32'(clr_cnt_reg) < 32'(WEIGHT_ENTRIES)) begin
                wmem[WADDR_W'(clr_cnt_reg)] <= '0;
            end
        end else if (wr.en && !wr.bank) begin
            wmem[WADDR_W'(wr.idx)] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            if (32'(clr_cnt_reg) < 32'(BIAS_ENTRIES)) begin
                bmem[BADDR_W'(clr_cnt_reg)] <= '0;
            end
        end else if (wr.en && wr.bank) begin
            bmem[BADDR_W'(wr.idx)] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            wrd_reg   <= wmem[WADDR_W'(rd_idx)];
            brd_reg   <= bmem[BADDR_W'(rd_idx)];
            rbank_reg <= rd_bank;
        end
    end

    assign rd_data = rbank_reg ? brd_reg : wrd_reg;
    assign busy    = busy_reg;

endmodule

[rtl/core/aou_corr.sv]
// ----------------------------------------------------------------------------
// aou_corr
// Bias correction and step: pipelined dividers, square root and final sum.
// ----------------------------------------------------------------------------
module aou_corr import aou_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic [31:0] lr,
    input  logic [23:0] eps,
    input  corr_in_t    din,
    output res_t        res
);

    typedef struct packed {
        hdr_t        hdr;
        logic [32:0] d1;
        logic [32:0] d2;
        logic [31:0] mrem;
        logic [31:0] mq;
        logic        msat;
        logic [31:0] vrem;
        logic [47:0] vq;
        logic        vsat;
        logic [15:0] vlow;
    } va_t;

    typedef struct packed {
        hdr_t        hdr;
        logic [30:0] mh;
        logic [33:0] rem;
        logic [31:0] root;
        logic [63:0] x;
    } vb_t;

    typedef struct packed {
        hdr_t        hdr;
        logic [48:0] den;
        logic [62:0] num;
    } c0_t;

    typedef struct packed {
        hdr_t        hdr;
        logic [48:0] den;
        logic [48:0] rem;
        logic [31:0] q;
        logic [31:0] low;
        logic        sat;
        logic        numz;
    } vc_t;

    va_t  a_reg [VH_STEPS+1];
    vb_t  b_reg [SQ_STEPS+1];
    vc_t  c_reg [DQ_STEPS+1];
    c0_t  c0_reg;
    res_t res_reg;

    va_t  a_init;
    vb_t  b_init;
    c0_t  c0_init;
    vc_t  c_init;
    res_t res_next;

    // division by d1 and d2
    always_comb begin
        a_init      = '0;
        a_init.hdr  = din.hdr;
        a_init.d1   = din.d1;
        a_init.d2   = din.d2;
        a_init.mrem = din.mmag;
        a_init.msat = {1'b0, din.mmag} >= din.d1;
        a_init.vrem = din.v[47:16];
        a_init.vsat = {1'b0, din.v} >= {din.d2, 16'b0};
        a_init.vlow = din.v[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg[0].hdr.valid <= 1'b0;
        end else if (en) begin
            a_reg[0] <= a_init;
        end
    end

    for (genvar k = 0; k < VH_STEPS; k++) begin : g_a
        va_t         nxt;
        logic [32:0] vs;
        if (k < MH_STEPS) begin : g_m
            logic [32:0] ms;
            always_comb begin
                nxt      = a_reg[k];
                vs       = div_step32(a_reg[k].vrem, a_reg[k].vlow[15], a_reg[k].d2);
                ms       = div_step32(a_reg[k].mrem, 1'b0, a_reg[k].d1);
                nxt.vrem = vs[31:0];
                nxt.vq   = {a_reg[k].vq[46:0], vs[32]};
                nxt.vlow = {a_reg[k].vlow[14:0], 1'b0};
                nxt.mrem = ms[31:0];
                nxt.mq   = {a_reg[k].mq[30:0], ms[32]};
            end
        end else begin : g_v
            always_comb begin
                nxt      = a_reg[k];
                vs       = div_step32(a_reg[k].vrem, a_reg[k].vlow[15], a_reg[k].d2);
                nxt.vrem = vs[31:0];
                nxt.vq   = {a_reg[k].vq[46:0], vs[32]};
                nxt.vlow = {a_reg[k].vlow[14:0], 1'b0};
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                a_reg[k+1].hdr.valid <= 1'b0;
            end else if (en) begin
                a_reg[k+1] <= nxt;
            end
        end
    end

    // square root of the corrected second moment
    always_comb begin
        b_init     = '0;
        b_init.hdr = a_reg[VH_STEPS].hdr;
        if (a_reg[VH_STEPS].msat || a_reg[VH_STEPS].mq[31]) begin
            b_init.mh = '1;
        end else begin
            b_init.mh = a_reg[VH_STEPS].mq[30:0];
        end
        if (a_reg[VH_STEPS].vsat) begin
            b_init.x = {48'hFFFF_FFFF_FFFF, 16'b0};
        end else begin
            b_init.x = {a_reg[VH_STEPS].vq, 16'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_reg[0].hdr.valid <= 1'b0;
        end else if (en) begin
            b_reg[0] <= b_init;
        end
    end

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_b
        vb_t         nxt;
        logic [65:0] st;
        always_comb begin
            nxt      = b_reg[k];
            st       = sqrt_step(b_reg[k].rem, b_reg[k].x[63:62], b_reg[k].root);
            nxt.root = st[65:34];
            nxt.rem  = st[33:0];
            nxt.x    = {b_reg[k].x[61:0], 2'b00};
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                b_reg[k+1].hdr.valid <= 1'b0;
            end else if (en) begin
                b_reg[k+1] <= nxt;
            end
        end
    end

    // step division
    always_comb begin
        c0_init.hdr = b_reg[SQ_STEPS].hdr;
        c0_init.den = 49'({b_reg[SQ_STEPS].root, 16'b0}) + 49'(eps);
        c0_init.num = 63'(b_reg[SQ_STEPS].mh) * 63'(lr);
    end

    always_comb begin
        c_init      = '0;
        c_init.hdr  = c0_reg.hdr;
        c_init.den  = c0_reg.den;
        c_init.sat  = {10'b0, c0_reg.num} >= {c0_reg.den, 24'b0};
        c_init.numz = (c0_reg.num == '0);
        c_init.rem  = 49'(c0_reg.num[62:24]);
        c_init.low  = {c0_reg.num[23:0], 8'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c0_reg.hdr.valid   <= 1'b0;
            c_reg[0].hdr.valid <= 1'b0;
        end else if (en) begin
            c0_reg   <= c0_init;
            c_reg[0] <= c_init;
        end
    end

    for (genvar k = 0; k < DQ_STEPS; k++) begin : g_c
        vc_t         nxt;
        logic [49:0] st;
        always_comb begin
            nxt     = c_reg[k];
            st      = div_step49(c_reg[k].rem, c_reg[k].low[31], c_reg[k].den);
            nxt.rem = st[48:0];
            nxt.q   = {c_reg[k].q[30:0], st[49]};
            nxt.low = {c_reg[k].low[30:0], 1'b0};
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                c_reg[k+1].hdr.valid <= 1'b0;
            end else if (en) begin
                c_reg[k+1] <= nxt;
            end
        end
    end

    // apply and saturate
    logic [32:0]        delta;
    logic signed [33:0] wsum;
    always_comb begin
        if (c_reg[DQ_STEPS].sat) begin
            delta = c_reg[DQ_STEPS].numz ? 33'd0 : ONE_Q32;
        end else begin
            delta = {1'b0, c_reg[DQ_STEPS].q};
        end
        if (c_reg[DQ_STEPS].hdr.neg) begin
            wsum = 34'(signed'(c_reg[DQ_STEPS].hdr.w)) + signed'({1'b0, delta});
        end else begin
            wsum = 34'(signed'(c_reg[DQ_STEPS].hdr.w)) - signed'({1'b0, delta});
        end
        res_next.valid = c_reg[DQ_STEPS].hdr.valid;
        res_next.bank  = c_reg[DQ_STEPS].hdr.bank;
        res_next.idx   = c_reg[DQ_STEPS].hdr.idx;
        if (!c_reg[DQ_STEPS].hdr.upd) begin
            res_next.nw = c_reg[DQ_STEPS].hdr.w;
        end else if (wsum > 34'sh0_7FFF_FFFF) begin
            res_next.nw = 32'h7FFF_FFFF;
        end else if (wsum < -34'sh0_8000_0000) begin
            res_next.nw = 32'h8000_0000;
        end else begin
            res_next.nw = wsum[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg.valid <= 1'b0;
        end else if (en) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

[rtl/core/adam_optimizer_update_top.sv]
// One request per cycle unless stalled: s_tready is low during the clearing
// sweep, while the output queue is full and a result waits, and when a request
// hits an element still in the two-stage moment read-modify-write window
// (one memory write port per bank). Reset: synchronous, active low; registers
// to defaults, beta powers to one, then a clearing sweep of the moment memories.
// ----------------------------------------------------------------------------
// adam_optimizer_update_top
// Adam element update with per-element moments held in on-chip memory.
// ----------------------------------------------------------------------------
module adam_optimizer_update_top import aou_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // index[11:0], weight[43:12], gradient[75:44]
    input  logic [1:0]  s_tuser,   // bank[0], start_of_pass[1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // new_weight[31:0], out_index[43:32]
    output logic        m_tuser,   // out_bank
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);

    logic [31:0] lr_reg;
    logic [23:0] b1_reg, b2_reg, eps_reg;
    logic [32:0] wp1_reg, wp2_reg, bp1_reg, bp2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lr_reg  <= LR_RST;
            b1_reg  <= B1_RST;
            b2_reg  <= B2_RST;
            eps_reg <= EPS_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_LEARNING_RATE: lr_reg  <= cfg_wdata;
                REG_BETA_ONE:      b1_reg  <= cfg_wdata[23:0];
                REG_BETA_TWO:      b2_reg  <= cfg_wdata[23:0];
                REG_EPSILON:       eps_reg <= cfg_wdata[23:0];
                default: ;
            endcase
        end
    end

    logic [IDX_W-1:0] in_idx;
    logic [31:0]      in_w, in_g;
    logic             in_bank, in_start, in_inr;
    assign in_idx   = s_tdata[11:0];
    assign in_w     = s_tdata[43:12];
    assign in_g     = s_tdata[75:44];
    assign in_bank  = s_tuser[0];
    assign in_start = s_tuser[1];
    assign in_inr   = in_bank ? (32'(in_idx) < 32'(BIAS_ENTRIES))
                              : (32'(in_idx) < 32'(WEIGHT_ENTRIES));

    // beta power advance
    logic [32:0] cur1, cur2, new1, new2;
    logic [56:0] adv1, adv2;
    always_comb begin
        cur1 = in_bank ? bp1_reg : wp1_reg;
        cur2 = in_bank ? bp2_reg : wp2_reg;
        adv1 = 57'(cur1) * 57'(b1_reg);
        adv2 = 57'(cur2) * 57'(b2_reg);
        new1 = in_start ? adv1[56:24] : cur1;
        new2 = in_start ? adv2[56:24] : cur2;
    end

    logic signed [63:0] gg;
    assign gg = $signed(in_g) * $signed(in_g);

    logic             p0_valid_reg, p0_inr_reg, p0_bank_reg;
    logic [IDX_W-1:0] p0_idx_reg;
    logic [31:0]      p0_w_reg, p0_g_reg;
    logic [47:0]      p0_sq_reg;
    logic [32:0]      p0_pa_reg, p0_pb_reg;

    logic                p1_valid_reg, p1_inr_reg, p1_bank_reg;
    logic [IDX_W-1:0]    p1_idx_reg;
    logic [31:0]         p1_w_reg;
    logic signed [57:0]  p1_ma_reg, p1_mb_reg;
    logic [48:0]         p1_vh1_reg, p1_vh2_reg, p1_vl1_reg, p1_vl2_reg;
    logic [32:0]         p1_d1_reg, p1_d2_reg;

    logic en, busy, hazard, accept, fifo_full;
    res_t c_res;
    mom_t rd_mom;
    mwr_t mwr;

    assign hazard = in_inr &&
        ((p0_valid_reg && p0_inr_reg && p0_bank_reg == in_bank && p0_idx_reg == in_idx) ||
         (p1_valid_reg && p1_inr_reg && p1_bank_reg == in_bank && p1_idx_reg == in_idx));
    assign en       = !c_res.valid || !fifo_full;
    assign s_tready = !busy && en && !hazard;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp1_reg <= ONE_Q32;
            wp2_reg <= ONE_Q32;
            bp1_reg <= ONE_Q32;
            bp2_reg <= ONE_Q32;
        end else if (accept && in_start) begin
            if (in_bank) begin
                bp1_reg <= new1;
                bp2_reg <= new2;
            end else begin
                wp1_reg <= new1;
                wp2_reg <= new2;
            end
        end
    end

    aou_mstore u_mstore (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_bank (in_bank),
        .rd_idx  (in_idx),
        .wr      (mwr),
        .rd_data (rd_mom),
        .busy    (busy)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_valid_reg <= 1'b0;
        end else if (en) begin
            p0_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p0_inr_reg  <= in_inr;
            p0_bank_reg <= in_bank;
            p0_idx_reg  <= in_idx;
            p0_w_reg    <= in_w;
            p0_g_reg    <= in_g;
            p0_sq_reg   <= gg[63:16];
            p0_pa_reg   <= new1;
            p0_pb_reg   <= new2;
        end
    end

    // moment products
    logic [24:0] b1c, b2c;
    assign b1c = ONE_Q24 - {1'b0, b1_reg};
    assign b2c = ONE_Q24 - {1'b0, b2_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= p0_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_inr_reg  <= p0_inr_reg;
            p1_bank_reg <= p0_bank_reg;
            p1_idx_reg  <= p0_idx_reg;
            p1_w_reg    <= p0_w_reg;
            p1_ma_reg   <= $signed({1'b0, b1_reg}) * $signed(rd_mom.m);
            p1_mb_reg   <= $signed({1'b0, b1c}) * $signed(p0_g_reg);
            p1_vh1_reg  <= 49'(b2_reg) * 49'(rd_mom.v[47:24]);
            p1_vh2_reg  <= 49'(b2c) * 49'(p0_sq_reg[47:24]);
            p1_vl1_reg  <= 49'(b2_reg) * 49'(rd_mom.v[23:0]);
            p1_vl2_reg  <= 49'(b2c) * 49'(p0_sq_reg[23:0]);
            p1_d1_reg   <= ONE_Q32 - p0_pa_reg;
            p1_d2_reg   <= ONE_Q32 - p0_pb_reg;
        end
    end

    // moment sums and write-back
    logic signed [57:0] msum;
    logic [49:0]        vhi, vlo;
    logic [31:0]        m_new;
    logic [47:0]        v_new;
    corr_in_t           cin;

    always_comb begin
        msum  = p1_ma_reg + p1_mb_reg;
        m_new = msum[55:24];
        vhi   = 50'(p1_vh1_reg) + 50'(p1_vh2_reg);
        vlo   = 50'(p1_vl1_reg) + 50'(p1_vl2_reg);
        v_new = 48'(vhi + (vlo >> 24));

        mwr.en   = en && p1_valid_reg && p1_inr_reg;
        mwr.bank = p1_bank_reg;
        mwr.idx  = p1_idx_reg;
        mwr.data = '{m: m_new, v: v_new};

        cin.hdr.valid = p1_valid_reg;
        cin.hdr.upd   = p1_inr_reg && (p1_d1_reg != '0) && (p1_d2_reg != '0);
        cin.hdr.bank  = p1_bank_reg;
        cin.hdr.idx   = p1_idx_reg;
        cin.hdr.w     = p1_w_reg;
        cin.hdr.neg   = m_new[31];
        cin.mmag      = m_new[31] ? (32'd0 - m_new) : m_new;
        cin.v         = v_new;
        cin.d1        = p1_d1_reg;
        cin.d2        = p1_d2_reg;
    end

    aou_corr u_corr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .lr      (lr_reg),
        .eps     (eps_reg),
        .din     (cin),
        .res     (c_res)
    );

    // two-entry output queue
    res_t        fq_reg [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;
    logic        push, pop;
    res_t        head;

    assign fifo_full = (cnt_reg == 2'd2);
    assign push      = en && c_res.valid;
    assign pop       = m_tvalid && m_tready;
    assign head      = fq_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) begin
                wp_reg <= ~wp_reg;
            end
            if (pop) begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fq_reg[wp_reg] <= c_res;
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = {4'b0, head.idx, head.nw};
    assign m_tuser  = head.bank;

    a_no_req_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> !busy) else $error("request accepted during memory clear");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> cnt_reg != 2'd2) else $error("output queue overflow");

    a_rmw_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        (p0_valid_reg && p0_inr_reg && p1_valid_reg && p1_inr_reg) |->
        !(p0_bank_reg == p1_bank_reg && p0_idx_reg == p1_idx_reg))
        else $error("overlapping read-modify-write on one element");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> cnt_reg == $past(cnt_reg) - 2'd1)
        else $error("output queue count mismatch");

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Streams tensor elements through the Adam update block under several
// register settings and flow-control mixes, predicts each updated weight
// from a bit-exact fixed-point model of the moments and bias correction,
// and compares every returned element in order.
// ----------------------------------------------------------------------------
class adam_scoreboard;
    localparam int WENT = 4096;
    localparam int BENT = 256;
    localparam longint unsigned ONE32 = 64'h1_0000_0000;
    localparam longint unsigned ONE24 = 64'h100_0000;

    longint unsigned lr, b1, b2, eps;
    int              wm[WENT];
    longint unsigned wv[WENT];
    int              bm[BENT];
    longint unsigned bv[BENT];
    longint unsigned pw1, pw2, pb1, pb2;
    logic [44:0]     expected_q[$];
    int              errors;

    function new();
        lr = 4294967; b1 = 15099494; b2 = 16760438; eps = 10995;
        foreach (wm[i]) begin wm[i] = 0; wv[i] = 0; end
        foreach (bm[i]) begin bm[i] = 0; bv[i] = 0; end
        pw1 = ONE32; pw2 = ONE32; pb1 = ONE32; pb2 = ONE32;
        errors = 0;
    endfunction

    function void set_reg(aou_pkg::reg_idx_t a, logic [31:0] d);
        case (a)
            aou_pkg::REG_LEARNING_RATE: lr = d;
            aou_pkg::REG_BETA_ONE:      b1 = d[23:0];
            aou_pkg::REG_BETA_TWO:      b2 = d[23:0];
            aou_pkg::REG_EPSILON:       eps = d[23:0];
            default: ;
        endcase
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    static function longint unsigned sat_quot(longint unsigned num, int sh,
                                              longint unsigned den,
                                              longint unsigned limit);
        longint unsigned q, r;
        if (den == 0) return (num != 0) ? limit : 0;
        q = num / den;
        r = num % den;
        if (q >= limit) return limit;
        for (int i = 0; i < sh; i++) begin
            q = q << 1;
            r = r << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 1;
            end
            if (q >= limit) return limit;
        end
        return q;
    endfunction

    static function longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res, bt;
        res = 0;
        bt = 64'h4000_0000_0000_0000;
        while (bt > x) bt = bt >> 2;
        while (bt != 0) begin
            if (x >= res + bt) begin
                x = x - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    function void note_request(logic bank, logic sop, logic [11:0] idx,
                               logic [31:0] w, logic [31:0] g);
        longint          wi, gi, m, nw, mo;
        longint unsigned vo, sq, v, d1, d2, mmag, mh, vh, s, den, delta, bb, p1, p2;
        wi = longint'(signed'(w));
        gi = longint'(signed'(g));
        nw = wi;
        if (sop) begin
            if (bank) begin
                pb1 = (pb1 * b1) >> 24; pb2 = (pb2 * b2) >> 24;
            end else begin
                pw1 = (pw1 * b1) >> 24; pw2 = (pw2 * b2) >> 24;
            end
        end
        p1 = bank ? pb1 : pw1;
        p2 = bank ? pb2 : pw2;
        if (idx < (bank ? BENT : WENT)) begin
            mo = bank ? bm[idx] : wm[idx];
            vo = (bank ? bv[idx] : wv[idx]) & 64'hFFFF_FFFF_FFFF;
            m = (longint'(b1) * mo + longint'(ONE24 - b1) * gi) >>> 24;
            sq = longint'(gi * gi) >> 16;
            bb = ONE24 - b2;
            v = b2 * (vo >> 24) + bb * (sq >> 24)
                + ((b2 * (vo & (ONE24 - 1)) + bb * (sq & (ONE24 - 1))) >> 24);
            v = v & 64'hFFFF_FFFF_FFFF;
            if (bank) begin bm[idx] = int'(m); bv[idx] = v; end
            else begin wm[idx] = int'(m); wv[idx] = v; end
            d1 = ONE32 - p1;
            d2 = ONE32 - p2;
            if (d1 != 0 && d2 != 0) begin
                mmag = (m < 0) ? longint'(-m) : longint'(m);
                mh = sat_quot(mmag, 32, d1, 64'h7FFF_FFFF);
                vh = sat_quot(v, 32, d2, 64'hFFFF_FFFF_FFFF);
                s = int_sqrt(vh << 16);
                den = (s << 16) + eps;
                delta = sat_quot(mh * lr, 8, den, ONE32);
                nw = (m < 0) ? wi + longint'(delta) : wi - longint'(delta);
                if (nw > 64'sd2147483647) nw = 64'sd2147483647;
                if (nw < -64'sd2147483648) nw = -64'sd2147483648;
            end
        end
        expected_q.push_back({bank, idx, nw[31:0]});
    endfunction

    function void check_result(logic [47:0] data, logic user);
        logic [44:0] exp_item;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result new_weight=%h index=%0d bank=%0d",
                     $time, data[31:0], data[43:32], user);
            errors++;
            return;
        end
        exp_item = expected_q.pop_front();
        if (data[31:0] !== exp_item[31:0]) begin
            $display("%0t: new_weight mismatch expected %h actual %h", $time,
                     exp_item[31:0], data[31:0]);
            errors++;
        end
        if (data[43:32] !== exp_item[43:32]) begin
            $display("%0t: out_index mismatch expected %0d actual %0d", $time,
                     exp_item[43:32], data[43:32]);
            errors++;
        end
        if (user !== exp_item[44]) begin
            $display("%0t: out_bank mismatch expected %0d actual %0d", $time,
                     exp_item[44], user);
            errors++;
        end
    endfunction
endclass

module tb;
    import aou_pkg::*;

    localparam int QUIET_LIMIT = 30000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [31:0] cfg_wdata = '0;

    adam_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_off = 0;
    int  quiet = 0;

    adam_optimizer_update_top dut (.*);

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (hold_off) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("adam_optimizer_update_top regression: fail");
                $finish;
            end
        end
    end

    task automatic send_request(logic bank, logic sop, logic [11:0] idx,
                                logic [31:0] w, logic [31:0] g);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, g, w, idx};
        s_tuser  <= {sop, bank};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(bank, sop, idx, w, g);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (130) @(posedge aclk);
    endtask

    task automatic write_reg(reg_idx_t a, logic [31:0] d);
        cfg_we    <= 1'b1;
        cfg_addr  <= a;
        cfg_wdata <= d;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.set_reg(a, d);
    endtask

    function automatic logic [31:0] rand_value();
        logic [31:0] r;
        case ($urandom_range(3))
            0: r = $urandom;
            1: r = $urandom >> $urandom_range(31);
            2: r = -($urandom >> $urandom_range(31));
            default: r = $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(3)
                                           : 32'h8000_0000 + $urandom_range(3);
        endcase
        return r;
    endfunction

    task automatic random_passes(int n);
        int   sent, len, base;
        logic bank;
        logic [11:0] idx;
        sent = 0;
        while (sent < n) begin
            bank = 1'($urandom_range(1));
            len  = $urandom_range(1, 24);
            base = $urandom_range(bank ? 240 : 4080);
            for (int i = 0; i < len && sent < n; i++) begin
                case ($urandom_range(9))
                    0: idx = 12'($urandom);
                    1: idx = 12'(base + $urandom_range(3));
                    default: idx = 12'(base + $urandom_range(15));
                endcase
                send_request(bank, (i == 0) || ($urandom_range(19) == 0), idx,
                             rand_value(), rand_value());
                sent++;
            end
        end
    endtask

    initial begin
        logic [31:0] set_lr[8] = '{32'd4294967, 32'hFFFF_FFFF, 32'd0, 32'h0100_0000,
                                   32'd4294967, 32'h8000_0000, 32'd1, 32'h0FFF_0000};
        logic [23:0] set_b1[8] = '{24'd15099494, 24'hFF_FFFF, 24'd0, 24'h80_0000,
                                   24'd1, 24'hE0_0000, 24'd15099494, 24'hF0_0000};
        logic [23:0] set_b2[8] = '{24'd16760438, 24'hFF_FFFF, 24'd0, 24'hC0_0000,
                                   24'hFF_FFFE, 24'd1, 24'd16760438, 24'hFF_0000};
        logic [23:0] set_eps[8] = '{24'd10995, 24'hFF_FFFF, 24'd0, 24'd1,
                                    24'd10995, 24'h00_1000, 24'd0, 24'd100};
        int idle_pct[4]  = '{0, 84, 0, 21};
        int stall_pct[4] = '{0, 0, 84, 21};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: no pass yet, extremes, both banks, index beyond bias bank
        send_request(1'b0, 1'b0, 12'd0, 32'h0100_0000, 32'h0001_0000);
        send_request(1'b0, 1'b1, 12'd0, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(1'b0, 1'b0, 12'd4095, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(1'b0, 1'b0, 12'd0, 32'hFFFF_FFFF, 32'h0);
        send_request(1'b1, 1'b0, 12'd5, 32'h0, 32'hFFFF_FFFF);
        send_request(1'b1, 1'b1, 12'd255, 32'h7FFF_FFFF, 32'hFFFF_0000);
        send_request(1'b1, 1'b0, 12'd256, 32'h1234_5678, 32'h7FFF_FFFF);
        send_request(1'b1, 1'b1, 12'd4095, 32'hAAAA_AAAA, 32'h5555_5555);
        send_request(1'b1, 1'b0, 12'd255, 32'h5555_5555, 32'hAAAA_AAAA);
        send_request(1'b0, 1'b1, 12'd2048, 32'h8000_0000, 32'h0000_0001);
        drain();

        // zero denominator: betas and epsilon zero, tiny gradient
        write_reg(REG_BETA_ONE, 32'd0);
        write_reg(REG_BETA_TWO, 32'd0);
        write_reg(REG_EPSILON, 32'd0);
        write_reg(REG_LEARNING_RATE, 32'hFFFF_FFFF);
        send_request(1'b0, 1'b1, 12'd7, 32'h0, 32'h0000_0001);
        send_request(1'b0, 1'b0, 12'd8, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(1'b0, 1'b0, 12'd9, 32'h0100_0000, 32'h0);
        send_request(1'b1, 1'b1, 12'd3, 32'h7FFF_FFFF, 32'h0000_00FF);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_LEARNING_RATE, set_lr[ph]);
            write_reg(REG_BETA_ONE, {8'h0, set_b1[ph]});
            write_reg(REG_BETA_TWO, {8'h0, set_b2[ph]});
            write_reg(REG_EPSILON, {8'h0, set_eps[ph]});
            send_idle_pct  = idle_pct[ph % 4];
            recv_stall_pct = stall_pct[ph % 4];
            if (ph == 4) begin
                send_idle_pct = 0;
                fork
                    begin
                        hold_off = 1;
                        repeat (600) @(posedge aclk);
                        hold_off = 0;
                    end
                join_none
            end
            random_passes(200);
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("adam_optimizer_update_top regression: pass");
        end else begin
            $display("adam_optimizer_update_top regression: fail");
        end
        $finish;
    end
endmodule

[adam_optimizer_update_top.f]
rtl/core/aou_pkg.sv
rtl/core/aou_mstore.sv
rtl/core/aou_corr.sv
rtl/core/adam_optimizer_update_top.sv
dv/tb.sv
